// File: rtl/overwriting_ring_buffer_macros.svh
// Assertion macros for the overwriting ring buffer.
`ifndef OVERWRITING_RING_BUFFER_MACROS_SVH
`define OVERWRITING_RING_BUFFER_MACROS_SVH

`ifndef SYNTH

`define OBR_ASSERT_IMP(label, clk, rst_n, a, b, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
		else $error(msg);

`define OBR_ASSERT_NXT(label, clk, rst_n, a, b, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
		else $error(msg);

`else

`define OBR_ASSERT_IMP(label, clk, rst_n, a, b, msg)

`define OBR_ASSERT_NXT(label, clk, rst_n, a, b, msg)

`endif

`endif

// File: rtl/obr_pkg.sv
// Package: field widths, operation codes and payload types of the ring buffer.
`timescale 1ns / 1ps
`default_nettype none

package obr_pkg;

	localparam int FUNC_W    = 2;
	localparam int ENTRY_W   = 64;
	localparam int COUNT_W   = 6;
	localparam int CFG_W     = 6;

	localparam int DEPTH_DEF      = 32;
	localparam int ENTRY_BITS_DEF = 64;

	localparam logic [CFG_W-1:0] RING_SIZE_RST = 6'd32;

	localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_LIST   = 2'd2;

	typedef struct packed {
		logic [FUNC_W-1:0]  func;
		logic [ENTRY_W-1:0] entry_data;
		logic [COUNT_W-1:0] remove_count;
	} obr_req_t;

	typedef struct packed {
		logic [ENTRY_W-1:0] entry_out;
		logic               last;
	} obr_rsp_t;

endpackage

`default_nettype wire

// File: rtl/obr_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module obr_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// File: rtl/overwriting_ring_buffer.sv
// Top level: overwriting ring buffer with slot RAM and listing sequencer.
//
// Channel   Direction  Handshake              Payload
// request   in         start && !busy         req (obr_req_t)
// result    out        rsp_valid, one cycle   rsp (obr_rsp_t)
// config    in         cfg_valid && cfg_ready cfg_data (ring size)
//
// Append and remove leave busy low; the next request is taken the cycle after.
// A list of N held entries reads one slot a cycle from the RAM read port and stays busy
// until the newest entry is read; each result follows its read in the next cycle (RAM latency).
// Reset empties the buffer at once; slot contents need no clearing.
// The receiver cannot stall; config is taken only with no request offered
// and no list or result pending.
`timescale 1ns / 1ps
`default_nettype none

`include "overwriting_ring_buffer_macros.svh"

module overwriting_ring_buffer #(
	parameter int DEPTH      = obr_pkg::DEPTH_DEF,
	parameter int ENTRY_BITS = obr_pkg::ENTRY_BITS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	output logic                          busy,
	input  wire obr_pkg::obr_req_t        req,
	output logic                          rsp_valid,
	output obr_pkg::obr_rsp_t             rsp,
	input  wire logic                     cfg_valid,
	output logic                          cfg_ready,
	input  wire logic [obr_pkg::CFG_W-1:0] cfg_data
);

	localparam int IW = $clog2(DEPTH);
	localparam int SW = $clog2(DEPTH + 1);
	localparam int CW = (SW > obr_pkg::CFG_W) ? SW : obr_pkg::CFG_W;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_LIST = 1'b1;

	logic                      state_q;
	logic [obr_pkg::CFG_W-1:0] ring_size_q;
	logic [IW-1:0]             head_q;
	logic [IW-1:0]             tail_q;
	logic                      empty_q;
	logic [IW-1:0]             rd_idx_q;
	logic                      valid_s1;
	logic                      last_s1;

	logic [SW-1:0]         size_c;
	logic                  accept;
	logic                  we;
	logic [IW-1:0]         waddr;
	logic                  re;
	logic [ENTRY_BITS-1:0] rdata;
	logic [IW-1:0]         nt_c;
	logic [SW-1:0]         held_c;
	logic [CW:0]           hsum_c;
	logic [CW:0]           hwrap_c;

	function automatic logic [IW-1:0] next_slot(input logic [IW-1:0] idx,
		input logic [SW-1:0] size);
		logic [SW-1:0] inc;
		inc = SW'(idx) + SW'(1);
		return (inc >= size) ? '0 : inc[IW-1:0];
	endfunction

	always_comb begin
		if (ring_size_q == '0) begin
			size_c = SW'(1);
		end else if (CW'(ring_size_q) > CW'(DEPTH)) begin
			size_c = SW'(DEPTH);
		end else begin
			size_c = SW'(ring_size_q);
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = !busy && !start && !valid_s1;
	assign accept    = start && !busy;

	assign nt_c = next_slot(tail_q, size_c);

	always_comb begin
		if (tail_q >= head_q) begin
			held_c = SW'(tail_q) - SW'(head_q) + SW'(1);
		end else begin
			held_c = SW'(tail_q) + size_c - SW'(head_q) + SW'(1);
		end
		hsum_c  = (CW + 1)'(head_q) + (CW + 1)'(req.remove_count);
		hwrap_c = (hsum_c >= (CW + 1)'(size_c)) ? hsum_c - (CW + 1)'(size_c) : hsum_c;
	end

	assign we    = accept && (req.func == obr_pkg::FUNC_APPEND);
	assign waddr = empty_q ? '0 : nt_c;
	assign re    = (state_q == ST_LIST);

	obr_ram #(
		.WIDTH(ENTRY_BITS),
		.DEPTH(DEPTH)
	) u_slots (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(req.entry_data[ENTRY_BITS-1:0]),
		.re   (re),
		.raddr(rd_idx_q),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ring_size_q <= obr_pkg::RING_SIZE_RST;
			head_q      <= '0;
			tail_q      <= '0;
			empty_q     <= 1'b1;
			rd_idx_q    <= '0;
			valid_s1    <= 1'b0;
			last_s1     <= 1'b0;
		end else begin
			valid_s1 <= re;
			last_s1  <= re && (rd_idx_q == tail_q);
			if (cfg_valid && cfg_ready) begin
				ring_size_q <= cfg_data;
				head_q      <= '0;
				tail_q      <= '0;
				empty_q     <= 1'b1;
			end else if (state_q == ST_LIST) begin
				if (rd_idx_q == tail_q) begin
					state_q <= ST_IDLE;
				end else begin
					rd_idx_q <= next_slot(rd_idx_q, size_c);
				end
			end else if (accept) begin
				case (req.func)
					obr_pkg::FUNC_APPEND: begin
						if (empty_q) begin
							head_q  <= '0;
							tail_q  <= '0;
							empty_q <= 1'b0;
						end else begin
							if (nt_c == head_q) begin
								head_q <= next_slot(nt_c, size_c);
							end
							tail_q <= nt_c;
						end
					end
					obr_pkg::FUNC_REMOVE: begin
						if (!empty_q && (req.remove_count != '0)) begin
							if (CW'(req.remove_count) >= CW'(held_c)) begin
								head_q  <= '0;
								tail_q  <= '0;
								empty_q <= 1'b1;
							end else begin
								head_q <= hwrap_c[IW-1:0];
							end
						end
					end
					obr_pkg::FUNC_LIST: begin
						if (!empty_q) begin
							state_q  <= ST_LIST;
							rd_idx_q <= head_q;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign rsp_valid     = valid_s1;
	assign rsp.entry_out = obr_pkg::ENTRY_W'(rdata);
	assign rsp.last      = last_s1;

	`OBR_ASSERT_NXT(a_list_starts, clk, arst_n,
		accept && (req.func == obr_pkg::FUNC_LIST) && !empty_q, state_q == ST_LIST,
		"list of a non-empty buffer did not start")
	`OBR_ASSERT_NXT(a_last_ends, clk, arst_n, rsp_valid && rsp.last, !rsp_valid,
		"result follows the newest entry of a listing")
	`OBR_ASSERT_IMP(a_idx_range, clk, arst_n, !empty_q,
		(SW'(head_q) < size_c) && (SW'(tail_q) < size_c),
		"head or tail beyond ring size")
	`OBR_ASSERT_NXT(a_rsp_from_read, clk, arst_n, !re, !rsp_valid,
		"result without a slot read")

endmodule

`default_nettype wire

// File: sim/overwriting_ring_buffer_tb.sv
// Testbench for the overwriting ring buffer: directed and random requests, checked against a predictor.
`timescale 1ns / 1ps

module overwriting_ring_buffer_tb;
	import obr_pkg::*;

	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
	localparam int unsigned SLOTS = DEPTH_DEF;
	localparam int unsigned SETTLE_CYCLES = 4;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	obr_req_t req;
	logic rsp_valid;
	obr_rsp_t rsp;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_W-1:0] cfg_data;

	logic [ENTRY_W-1:0] ring_slots [SLOTS];
	int unsigned oldest_idx;
	int unsigned newest_idx;
	bit ring_empty;
	logic [CFG_W-1:0] ring_size_reg;
	obr_rsp_t expected_entries [$];
	int unsigned mismatches;
	bit burst_mode;

	overwriting_ring_buffer dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp(rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned slots_in_use();
		if (ring_size_reg == 0)
			return 1;
		if (ring_size_reg > SLOTS)
			return SLOTS;
		return 32'(ring_size_reg);
	endfunction

	function automatic int unsigned advance(input int unsigned idx);
		return (idx + 1 >= slots_in_use()) ? 0 : idx + 1;
	endfunction

	function automatic void clear_ring();
		oldest_idx = 0;
		newest_idx = 0;
		ring_empty = 1'b1;
	endfunction

	function automatic obr_req_t make_req(input logic [FUNC_W-1:0] f,
			input logic [ENTRY_W-1:0] d, input logic [COUNT_W-1:0] n);
		obr_req_t r;
		r.func = f;
		r.entry_data = d;
		r.remove_count = n;
		return r;
	endfunction

	// Updates the ring and queues the entries a list request should emit.
	function automatic void apply_request(input obr_req_t r);
		int unsigned nt;
		int unsigned idx;
		int unsigned left;
		int unsigned emitted;
		obr_rsp_t e;
		case (r.func)
			FUNC_APPEND: begin
				if (ring_empty) begin
					oldest_idx = 0;
					newest_idx = 0;
					ring_empty = 1'b0;
				end else begin
					nt = advance(newest_idx);
					if (nt == oldest_idx)
						oldest_idx = advance(nt);
					newest_idx = nt;
				end
				ring_slots[newest_idx] = r.entry_data;
			end
			FUNC_REMOVE: begin
				left = 32'(r.remove_count);
				while (left > 0 && !ring_empty) begin
					if (oldest_idx == newest_idx)
						clear_ring();
					else
						oldest_idx = advance(oldest_idx);
					left--;
				end
			end
			FUNC_LIST: begin
				if (!ring_empty) begin
					idx = oldest_idx;
					emitted = 0;
					forever begin
						e.entry_out = ring_slots[idx];
						e.last = (idx == newest_idx);
						expected_entries.push_back(e);
						emitted++;
						if (idx == newest_idx || emitted >= SLOTS)
							break;
						idx = advance(idx);
					end
				end
			end
			default: ;
		endcase
	endfunction

	always @(posedge clk) begin
		obr_rsp_t e;
		if (arst_n && rsp_valid) begin
			if (expected_entries.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: entry_out=%h last=%b", rsp.entry_out, rsp.last);
			end else begin
				e = expected_entries.pop_front();
				if (rsp.entry_out !== e.entry_out || rsp.last !== e.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected entry_out=%h last=%b, got entry_out=%h last=%b",
							e.entry_out, e.last, rsp.entry_out, rsp.last);
				end
			end
		end
	end

	task automatic send_request(input obr_req_t r);
		int unsigned gap;
		gap = burst_mode ? 0 : $urandom_range(0, 15);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy);
		apply_request(r);
		if ($urandom_range(0, 9) == 0)
			burst_mode = !burst_mode;
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		@(posedge clk);
		while (expected_entries.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_ring_size(input logic [CFG_W-1:0] sz);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data <= sz;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		ring_size_reg = sz;
		clear_ring();
	endtask

	task automatic apply_and_send_append();
		send_request(make_req(FUNC_APPEND, {$urandom, $urandom}, '0));
	endtask

	task automatic test_empty_buffer();
		send_request(make_req(FUNC_LIST, '0, '0));
		send_request(make_req(FUNC_REMOVE, '0, 6'd5));
		send_request(make_req(FUNC_UNUSED, '1, '1));
		send_request(make_req(FUNC_REMOVE, '1, '0));
		send_request(make_req(FUNC_LIST, '1, '1));
		wait_idle();
	endtask

	task automatic test_append_and_overwrite();
		set_ring_size(6'd3);
		send_request(make_req(FUNC_APPEND, '0, '1));
		send_request(make_req(FUNC_APPEND, '1, '0));
		send_request(make_req(FUNC_APPEND, 64'h5555_5555_5555_5555, '0));
		send_request(make_req(FUNC_LIST, '0, '0));
		send_request(make_req(FUNC_APPEND, 64'hAAAA_AAAA_AAAA_AAAA, '0));
		send_request(make_req(FUNC_UNUSED, '0, '0));
		send_request(make_req(FUNC_LIST, '0, '0));
		wait_idle();
	endtask

	task automatic test_remove();
		send_request(make_req(FUNC_REMOVE, '0, '0));
		send_request(make_req(FUNC_REMOVE, '0, 6'd1));
		send_request(make_req(FUNC_LIST, '0, '0));
		send_request(make_req(FUNC_REMOVE, '0, 6'd63));
		send_request(make_req(FUNC_LIST, '0, '0));
		send_request(make_req(FUNC_APPEND, 64'h0123_4567_89AB_CDEF, '0));
		send_request(make_req(FUNC_LIST, '0, '0));
		wait_idle();
	endtask

	task automatic test_ring_size_limits();
		set_ring_size(6'd0);
		send_request(make_req(FUNC_APPEND, 64'hDEAD_BEEF_0000_0001, '0));
		send_request(make_req(FUNC_APPEND, 64'hDEAD_BEEF_0000_0002, '0));
		send_request(make_req(FUNC_LIST, '0, '0));
		set_ring_size(6'd63);
		repeat (34)
			apply_and_send_append();
		send_request(make_req(FUNC_LIST, '0, '0));
		wait_idle();
	endtask

	task automatic test_random_traffic();
		logic [CFG_W-1:0] sizes [8] = '{6'd4, 6'd1, 6'd32, 6'd0, 6'd63, 6'd2, 6'd9, 6'd45};
		int unsigned counts [8] = '{25, 20, 55, 20, 30, 20, 25, 27};
		obr_req_t r;
		int unsigned sel;
		for (int p = 0; p < 8; p++) begin
			set_ring_size(sizes[p]);
			for (int i = 0; i < counts[p]; i++) begin
				sel = $urandom_range(0, 99);
				r.entry_data = {$urandom, $urandom};
				r.remove_count = COUNT_W'(($urandom_range(0, 3) == 0)
					? $urandom_range(0, 63) : $urandom_range(0, 3));
				if (sel < 50)
					r.func = FUNC_APPEND;
				else if (sel < 62)
					r.func = FUNC_REMOVE;
				else if (sel < 95)
					r.func = FUNC_LIST;
				else
					r.func = FUNC_UNUSED;
				send_request(r);
			end
		end
		send_request(make_req(FUNC_LIST, '0, '0));
		wait_idle();
	endtask

	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		req <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		mismatches = 0;
		burst_mode = 1'b0;
		ring_size_reg = RING_SIZE_RST;
		clear_ring();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_buffer();
		test_append_and_overwrite();
		test_remove();
		test_ring_size_limits();
		test_random_traffic();
		wait_idle();
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
